// ===== rtl/core/keypad_debounce_hold_detect_unit_macros.svh =====
// assertion macros for the keypad debounce and hold detect unit
`ifndef KEYPAD_DEBOUNCE_HOLD_DETECT_UNIT_MACROS_SVH
`define KEYPAD_DEBOUNCE_HOLD_DETECT_UNIT_MACROS_SVH
`ifndef SYNTH
// condition implies consequence in the same cycle
`define KDHD_ASSERT_NOW(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("kdhd assertion failed");
// condition implies consequence in the next cycle
`define KDHD_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("kdhd assertion failed");
`else
`define KDHD_ASSERT_NOW(label, clk, rst, cond, cons)
`define KDHD_ASSERT_NEXT(label, clk, rst, cond, cons)
`endif
`endif

// ===== rtl/core/kdhd_pkg.sv =====
// shared types and constants of the keypad debounce and hold detect unit
`default_nettype none
package kdhd_pkg;
   localparam int NUM_BUTTONS = 9;
   localparam int COUNT_WIDTH = 8;
   localparam int THR_W       = 8;
   localparam int ROW_W       = 3;
   localparam int KIND_W      = 2;
   localparam int CSR_IDX_W   = 2;
   localparam int CMP_W       = (COUNT_WIDTH > THR_W) ? COUNT_WIDTH : THR_W;

   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

   typedef enum logic [KIND_W-1:0] {
      KIND_SCAN  = 2'd0,
      KIND_POLL  = 2'd1,
      KIND_CLEAR = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_THR   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_THR = 2'd1;

   // control from the top level to every button cell
   typedef struct packed {
      logic             update;
      logic             raw_zero;
      logic [THR_W-1:0] press_thr;
      logic [THR_W-1:0] release_thr;
   } scan_ctl_type;

   // status from one button cell
   typedef struct packed {
      logic pressed;
      logic pressed_next;
      logic held_hit;
   } cell_stat_type;
endpackage
`default_nettype wire

// ===== rtl/core/keypad_debounce_hold_detect_unit.sv =====
// Keypad debounce and hold detect unit: a 3x3 active-low button matrix is
// debounced with per-button press and release counters; a saturating hold
// counter sets a sticky held bit. Every item (scan, poll, clear or none)
// gives one result. Items are taken into an input register and the work is
// done between that register and the result register, so one item is
// accepted every cycle; the only limit is the result register, which holds
// while rsp_stall is high. Thresholds are written over the csr port, which
// is always ready.
`default_nettype none
`include "keypad_debounce_hold_detect_unit_macros.svh"
module keypad_debounce_hold_detect_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [kdhd_pkg::KIND_W-1:0]      req_kind,
   input  wire logic [kdhd_pkg::ROW_W-1:0]       req_row_top,
   input  wire logic [kdhd_pkg::ROW_W-1:0]       req_row_middle,
   input  wire logic [kdhd_pkg::ROW_W-1:0]       req_row_bottom,
   input  wire logic [kdhd_pkg::NUM_BUTTONS-1:0] req_button_mask,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [kdhd_pkg::NUM_BUTTONS-1:0]      rsp_pressed_vector,
   output logic [kdhd_pkg::NUM_BUTTONS-1:0]      rsp_held_vector,
   output logic [kdhd_pkg::NUM_BUTTONS-1:0]      rsp_released_events,
   output logic                                  rsp_activity,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [kdhd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [kdhd_pkg::THR_W-1:0]       csr_data
);
   localparam int NB = kdhd_pkg::NUM_BUTTONS;

   logic [kdhd_pkg::THR_W-1:0] press_thr_ff, release_thr_ff;

   logic                       in_valid_ff;
   kdhd_pkg::kind_type         kind_ff;
   logic [kdhd_pkg::ROW_W-1:0] top_ff, mid_ff, bot_ff;
   logic [NB-1:0]              mask_ff;

   logic          out_valid_ff;
   logic [NB-1:0] pressed_ff, held_out_ff, events_ff;
   logic          activity_ff;

   logic [NB-1:0] held_ff, held_in;
   logic [NB-1:0] pressed_in, events_in, raw, deb_now, deb_next, hit;
   logic          activity_in, advance, step;

   kdhd_pkg::scan_ctl_type  ctl;
   kdhd_pkg::cell_stat_type stat [NB];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         press_thr_ff   <= 8'd3;
         release_thr_ff <= 8'd3;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            kdhd_pkg::CSR_PRESS_THR:   press_thr_ff   <= csr_data;
            kdhd_pkg::CSR_RELEASE_THR: release_thr_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // input stage moves on whenever the result register is free or drains
   assign advance   = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance || !in_valid_ff) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         kind_ff <= kdhd_pkg::kind_type'(req_kind);
         top_ff  <= req_row_top;
         mid_ff  <= req_row_middle;
         bot_ff  <= req_row_bottom;
         mask_ff <= req_button_mask;
      end
   end

   assign raw = ~{top_ff, mid_ff, bot_ff};

   assign ctl.update      = step && (kind_ff == kdhd_pkg::KIND_SCAN);
   assign ctl.raw_zero    = (raw == '0);
   assign ctl.press_thr   = press_thr_ff;
   assign ctl.release_thr = release_thr_ff;

   for (genvar b = 0; b < NB; b++) begin : g_cell
      kdhd_button_cell u_cell (
         .clock (clock),
         .reset (reset),
         .ctl   (ctl),
         .raw   (raw[b]),
         .stat  (stat[b])
      );
      assign deb_now[b]  = stat[b].pressed;
      assign deb_next[b] = stat[b].pressed_next;
      assign hit[b]      = stat[b].held_hit;
   end

   always_comb begin
      pressed_in  = deb_now;
      held_in     = held_ff;
      events_in   = '0;
      activity_in = 1'b0;
      unique case (kind_ff)
         kdhd_pkg::KIND_SCAN: begin
            pressed_in  = deb_next;
            held_in     = held_ff | hit;
            activity_in = !ctl.raw_zero;
         end
         kdhd_pkg::KIND_POLL: begin
            events_in = held_ff & mask_ff & ~deb_now;
            held_in   = held_ff & ~events_in;
         end
         kdhd_pkg::KIND_CLEAR: begin
            held_in = held_ff & ~mask_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (step) begin
            held_ff <= held_in;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         pressed_ff  <= pressed_in;
         held_out_ff <= held_in;
         events_ff   <= events_in;
         activity_ff <= activity_in;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_pressed_vector  = pressed_ff;
   assign rsp_held_vector     = held_out_ff;
   assign rsp_released_events = events_ff;
   assign rsp_activity        = activity_ff;

   // released buttons are never reported as still pressed
   `KDHD_ASSERT_NOW(a_events_not_pressed, clock, reset, out_valid_ff,
      (events_ff & pressed_ff) == '0)
   // a reported release drops its held bit
   `KDHD_ASSERT_NOW(a_events_clear_held, clock, reset, out_valid_ff,
      (events_ff & held_out_ff) == '0)
   // only a poll reports events and it never reports activity
   `KDHD_ASSERT_NOW(a_events_no_activity, clock, reset,
      out_valid_ff && (events_ff != '0), !activity_ff)
   // a drained result with nothing behind it leaves the output empty
   `KDHD_ASSERT_NEXT(a_drain_empty, clock, reset,
      out_valid_ff && !rsp_stall && !in_valid_ff, !out_valid_ff)
   // the input side stalls only with an item waiting in the input register
   `KDHD_ASSERT_NOW(a_stall_needs_item, clock, reset, req_stall,
      in_valid_ff && out_valid_ff)
endmodule
`default_nettype wire

// ===== rtl/core/kdhd_button_cell.sv =====
// one button: press, release and hold counters with its debounced bit
`default_nettype none
module kdhd_button_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire kdhd_pkg::scan_ctl_type ctl,
   input  wire logic                   raw,
   output kdhd_pkg::cell_stat_type     stat
);
   localparam int CNT_W = kdhd_pkg::COUNT_WIDTH;
   localparam int CMP_W = kdhd_pkg::CMP_W;

   logic [CNT_W-1:0] press_ff,   press_in;
   logic [CNT_W-1:0] release_ff, release_in;
   logic [CNT_W-1:0] hold_ff,    hold_in;
   logic             deb_ff,     deb_in;
   logic [CNT_W-1:0] press_inc, release_inc, hold_inc;

   assign press_inc   = press_ff + CNT_W'(1);
   assign release_inc = release_ff + CNT_W'(1);
   assign hold_inc    = hold_ff + CNT_W'(1);

   always_comb begin
      press_in   = raw ? press_inc : press_ff;
      release_in = raw ? release_ff : release_inc;
      deb_in     = deb_ff;
      if (CMP_W'(press_in) > CMP_W'(ctl.press_thr)) begin
         deb_in   = 1'b1;
         press_in = '0;
      end
      if (CMP_W'(release_in) > CMP_W'(ctl.release_thr)) begin
         deb_in     = 1'b0;
         release_in = '0;
      end
      // hold count saturates while the debounced bit stays set
      if (deb_in) begin
         hold_in = (hold_ff == kdhd_pkg::CNT_MAX) ? hold_ff : hold_inc;
      end else begin
         hold_in = '0;
      end
   end

   assign stat.pressed      = deb_ff;
   assign stat.pressed_next = deb_in & ~ctl.raw_zero;
   assign stat.held_hit     = CMP_W'(hold_in) > CMP_W'(ctl.press_thr);

   always_ff @(posedge clock) begin
      if (reset) begin
         press_ff   <= '0;
         release_ff <= '0;
         hold_ff    <= '0;
         deb_ff     <= 1'b0;
      end else if (ctl.update) begin
         if (ctl.raw_zero) begin
            // all-released sample wipes the counters and debounced bit
            press_ff   <= '0;
            release_ff <= '0;
            hold_ff    <= '0;
            deb_ff     <= 1'b0;
         end else begin
            press_ff   <= press_in;
            release_ff <= release_in;
            hold_ff    <= hold_in;
            deb_ff     <= deb_in;
         end
      end
   end
endmodule
`default_nettype wire

// ===== bench/keypad_debounce_hold_detect_unit_checker.sv =====
`timescale 1ns / 1ps
// result checker for the keypad debounce and hold detect unit: tracks button state, compares results
module keypad_debounce_hold_detect_unit_checker
   import kdhd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [KIND_W-1:0]      req_kind,
   input  logic [ROW_W-1:0]       req_row_top,
   input  logic [ROW_W-1:0]       req_row_middle,
   input  logic [ROW_W-1:0]       req_row_bottom,
   input  logic [NUM_BUTTONS-1:0] req_button_mask,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [NUM_BUTTONS-1:0] rsp_pressed_vector,
   input  logic [NUM_BUTTONS-1:0] rsp_held_vector,
   input  logic [NUM_BUTTONS-1:0] rsp_released_events,
   input  logic                   rsp_activity,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [THR_W-1:0]       csr_data,
   output int unsigned            outstanding,
   output int unsigned            failures,
   output int unsigned            checked,
   output int unsigned            release_reports
);
   typedef struct packed {
      logic [NUM_BUTTONS-1:0] pressed;
      logic [NUM_BUTTONS-1:0] held;
      logic [NUM_BUTTONS-1:0] events;
      logic                   activity;
   } key_report_t;

   key_report_t            report_q[$];
   logic [THR_W-1:0]       press_thr;
   logic [THR_W-1:0]       release_thr;
   logic [NUM_BUTTONS-1:0] debounced;
   logic [NUM_BUTTONS-1:0] held;
   logic [COUNT_WIDTH-1:0] press_cnt[NUM_BUTTONS];
   logic [COUNT_WIDTH-1:0] release_cnt[NUM_BUTTONS];
   logic [COUNT_WIDTH-1:0] hold_cnt[NUM_BUTTONS];

   function automatic void clear_counters();
      int b;
      for (b = 0; b < NUM_BUTTONS; b++) begin
         press_cnt[b]   = '0;
         release_cnt[b] = '0;
         hold_cnt[b]    = '0;
      end
   endfunction

   function automatic key_report_t step_keypad(kind_type kind, logic [ROW_W-1:0] top,
                                               logic [ROW_W-1:0] mid, logic [ROW_W-1:0] bot,
                                               logic [NUM_BUTTONS-1:0] mask);
      key_report_t            rep;
      logic [NUM_BUTTONS-1:0] raw;
      int                     b;
      rep = '0;
      case (kind)
         KIND_SCAN: begin
            raw = {~top, ~mid, ~bot};
            rep.activity = |raw;
            for (b = 0; b < NUM_BUTTONS; b++) begin
               // press and release counts run independently of each other
               if (raw[b]) press_cnt[b] = press_cnt[b] + 1'b1;
               else release_cnt[b] = release_cnt[b] + 1'b1;
               if (press_cnt[b] > press_thr) begin
                  debounced[b] = 1'b1;
                  press_cnt[b] = '0;
               end
               if (release_cnt[b] > release_thr) begin
                  debounced[b]   = 1'b0;
                  release_cnt[b] = '0;
               end
            end
            for (b = 0; b < NUM_BUTTONS; b++) begin
               if (debounced[b]) begin
                  if (hold_cnt[b] != CNT_MAX) hold_cnt[b] = hold_cnt[b] + 1'b1;
               end else begin
                  hold_cnt[b] = '0;
               end
               if (hold_cnt[b] > press_thr) held[b] = 1'b1;
            end
            // all-released sample wipes debounce state but keeps held bits
            if (raw == '0) begin
               debounced = '0;
               clear_counters();
            end
         end
         KIND_POLL: begin
            rep.events = held & mask & ~debounced;
            held = held & ~rep.events;
         end
         KIND_CLEAR: begin
            held = held & ~mask;
         end
         default: begin
         end
      endcase
      rep.pressed = debounced;
      rep.held    = held;
      return rep;
   endfunction

   task automatic check_field(string name, logic [NUM_BUTTONS-1:0] want,
                              logic [NUM_BUTTONS-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %h, actual %h", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin : watch
      key_report_t want;
      if (reset) begin
         report_q.delete();
         press_thr       = 8'd3;
         release_thr     = 8'd3;
         debounced       = '0;
         held            = '0;
         clear_counters();
         failures        = 0;
         checked         = 0;
         release_reports = 0;
         outstanding    <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PRESS_THR:   press_thr = csr_data;
               CSR_RELEASE_THR: release_thr = csr_data;
               default: begin
               end
            endcase
         end
         // compare the result transfer before queueing this edge's request
         if (rsp_valid && !rsp_stall) begin
            if (report_q.size() == 0) begin
               $error("result transfer with nothing expected: pressed %h held %h",
                      rsp_pressed_vector, rsp_held_vector);
               failures++;
            end else begin
               want = report_q.pop_front();
               check_field("pressed_vector", want.pressed, rsp_pressed_vector);
               check_field("held_vector", want.held, rsp_held_vector);
               check_field("released_events", want.events, rsp_released_events);
               check_field("activity", NUM_BUTTONS'(want.activity),
                           NUM_BUTTONS'(rsp_activity));
               checked++;
               if (rsp_released_events != '0) release_reports++;
            end
         end
         if (req_valid && !req_stall)
            report_q.push_back(step_keypad(kind_type'(req_kind), req_row_top,
                                           req_row_middle, req_row_bottom,
                                           req_button_mask));
         outstanding <= report_q.size();
      end
   end
endmodule

// ===== bench/keypad_debounce_hold_detect_unit_tb.sv =====
`timescale 1ns / 1ps
// testbench top for the keypad debounce and hold detect unit: stimulus, idling and verdict
module keypad_debounce_hold_detect_unit_tb;
   import kdhd_pkg::*;

   localparam int                     WATCHDOG_LIMIT = 1000;
   localparam int                     END_HOLDOFF    = 8;
   localparam logic [CSR_IDX_W-1:0]   CSR_SPARE_IDX  = 2'd3;
   localparam logic [NUM_BUTTONS-1:0] ALL_BUTTONS    = 9'h1ff;
   localparam logic [NUM_BUTTONS-1:0] NO_KEYS        = 9'h000;
   localparam logic [ROW_W-1:0]       ROW_IDLE       = 3'd7;
   localparam logic [ROW_W-1:0]       ROW_ALL        = 3'd0;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [KIND_W-1:0]      req_kind;
   logic [ROW_W-1:0]       req_row_top;
   logic [ROW_W-1:0]       req_row_middle;
   logic [ROW_W-1:0]       req_row_bottom;
   logic [NUM_BUTTONS-1:0] req_button_mask;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [NUM_BUTTONS-1:0] rsp_pressed_vector;
   logic [NUM_BUTTONS-1:0] rsp_held_vector;
   logic [NUM_BUTTONS-1:0] rsp_released_events;
   logic                   rsp_activity;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [THR_W-1:0]       csr_data;

   int unsigned outstanding;
   int unsigned failures;
   int unsigned checked;
   int unsigned release_reports;
   int unsigned items_sent;
   int unsigned settings_run;
   int unsigned send_gap_pct;
   int unsigned recv_gap_pct;
   int unsigned idle_cycles;

   keypad_debounce_hold_detect_unit i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_row_top         (req_row_top),
      .req_row_middle      (req_row_middle),
      .req_row_bottom      (req_row_bottom),
      .req_button_mask     (req_button_mask),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_pressed_vector  (rsp_pressed_vector),
      .rsp_held_vector     (rsp_held_vector),
      .rsp_released_events (rsp_released_events),
      .rsp_activity        (rsp_activity),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   keypad_debounce_hold_detect_unit_checker i_check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_row_top         (req_row_top),
      .req_row_middle      (req_row_middle),
      .req_row_bottom      (req_row_bottom),
      .req_button_mask     (req_button_mask),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_pressed_vector  (rsp_pressed_vector),
      .rsp_held_vector     (rsp_held_vector),
      .rsp_released_events (rsp_released_events),
      .rsp_activity        (rsp_activity),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .outstanding         (outstanding),
      .failures            (failures),
      .checked             (checked),
      .release_reports     (release_reports)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // result side: stall bursts between runs of random length
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         if (recv_gap_pct != 0 && $urandom_range(0, 99) < recv_gap_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results pending",
                     WATCHDOG_LIMIT, outstanding);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   task automatic send_req(kind_type kind, logic [ROW_W-1:0] top, logic [ROW_W-1:0] mid,
                           logic [ROW_W-1:0] bot, logic [NUM_BUTTONS-1:0] mask);
      if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_row_top     <= top;
      req_row_middle  <= mid;
      req_row_bottom  <= bot;
      req_button_mask <= mask;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_scan(logic [NUM_BUTTONS-1:0] raw);
      send_req(KIND_SCAN, ~raw[8:6], ~raw[5:3], ~raw[2:0], NUM_BUTTONS'($urandom));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic csr_transfer(logic [CSR_IDX_W-1:0] idx, logic [THR_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // pattern runs with random content; noise is polls, clears, ignored kinds and stray scans
   task automatic run_random(int unsigned count, int unsigned min_run, int unsigned max_run,
                             int unsigned scan_pct, bit zero_ok);
      int unsigned            done;
      int unsigned            run;
      logic [NUM_BUTTONS-1:0] base;
      logic [NUM_BUTTONS-1:0] raw;
      done = 0;
      while (done < count) begin
         base = NUM_BUTTONS'($urandom_range(1, 511));
         run  = $urandom_range(min_run, max_run);
         for (int i = 0; i < run && done < count; i++) begin
            if ($urandom_range(0, 99) < scan_pct) begin
               raw = base;
               if ($urandom_range(0, 9) == 0) raw[$urandom_range(0, 8)] = ~raw[0];
               send_scan(raw);
            end else begin
               case ($urandom_range(0, 4))
                  0, 1: send_req(KIND_POLL, ROW_W'($urandom), ROW_W'($urandom),
                                 ROW_W'($urandom),
                                 $urandom_range(0, 1) ? ALL_BUTTONS : NUM_BUTTONS'($urandom));
                  2: send_req(KIND_CLEAR, ROW_W'($urandom), ROW_W'($urandom), ROW_W'($urandom),
                              NUM_BUTTONS'($urandom & $urandom));
                  3: begin
                     if (zero_ok) send_scan(NO_KEYS);
                     else send_req(KIND_NONE, ROW_W'($urandom), ROW_W'($urandom),
                                   ROW_W'($urandom), NUM_BUTTONS'($urandom));
                  end
                  default: begin
                     if ($urandom_range(0, 1)) send_scan(NUM_BUTTONS'($urandom));
                     else send_req(KIND_NONE, ROW_W'($urandom), ROW_W'($urandom),
                                   ROW_W'($urandom), NUM_BUTTONS'($urandom));
                  end
               endcase
            end
            if ($urandom_range(0, 199) == 0) wait_drained();
            done++;
         end
      end
   endtask

   task automatic run_setting(logic [THR_W-1:0] press_val, logic [THR_W-1:0] rel_val,
                              int unsigned count, int unsigned min_run, int unsigned max_run,
                              int unsigned scan_pct, bit zero_ok, int unsigned sgap,
                              int unsigned rgap);
      wait_drained();
      csr_transfer(CSR_PRESS_THR, press_val);
      csr_transfer(CSR_RELEASE_THR, rel_val);
      // the spare index must leave both thresholds alone
      csr_transfer(CSR_SPARE_IDX, THR_W'($urandom));
      csr_valid    <= 1'b0;
      send_gap_pct  = sgap;
      recv_gap_pct  = rgap;
      settings_run++;
      run_random(count, min_run, max_run, scan_pct, zero_ok);
   endtask

   initial begin
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_kind        <= KIND_SCAN;
      req_row_top     <= ROW_IDLE;
      req_row_middle  <= ROW_IDLE;
      req_row_bottom  <= ROW_IDLE;
      req_button_mask <= NO_KEYS;
      csr_valid       <= 1'b0;
      csr_index       <= CSR_PRESS_THR;
      csr_data        <= '0;
      items_sent       = 0;
      settings_run     = 1;
      send_gap_pct     = 25;
      recv_gap_pct     = 25;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset thresholds: press everything until held, then release in steps
      send_scan(NO_KEYS);
      repeat (8) send_scan(ALL_BUTTONS);
      send_req(KIND_POLL, ROW_IDLE, ROW_IDLE, ROW_IDLE, ALL_BUTTONS);
      repeat (4) send_scan(9'h1c0);
      send_req(KIND_POLL, ROW_ALL, ROW_ALL, ROW_ALL, 9'h00f);
      send_req(KIND_POLL, 3'd5, 3'd2, 3'd5, ALL_BUTTONS);
      send_req(KIND_CLEAR, ROW_ALL, ROW_ALL, ROW_ALL, ALL_BUTTONS);
      send_req(KIND_NONE, ROW_ALL, ROW_ALL, ROW_ALL, ALL_BUTTONS);
      send_scan(NO_KEYS);
      send_req(KIND_SCAN, 3'b110, 3'b101, 3'b011, NO_KEYS);
      send_req(KIND_POLL, ROW_IDLE, ROW_IDLE, ROW_IDLE, NO_KEYS);
      send_req(KIND_CLEAR, ROW_ALL, ROW_ALL, ROW_ALL, NO_KEYS);

      run_setting(8'd0, 8'd0, 150, 1, 30, 60, 1'b1, 30, 30);
      run_setting(8'd254, 8'd254, 650, 650, 650, 92, 1'b0, 20, 20);
      run_setting(8'd2, 8'd5, 200, 1, 40, 65, 1'b1, 0, 30);
      run_setting(THR_W'($urandom_range(0, 15)), THR_W'($urandom_range(0, 15)),
                  200, 1, 40, 65, 1'b1, 40, 40);
      run_setting(8'd1, 8'd0, 200, 1, 40, 65, 1'b1, 0, 0);

      wait_drained();
      repeat (END_HOLDOFF) @(posedge clock);
      $display("covered %0d requests over %0d threshold settings with random stalls",
               items_sent, settings_run);
      $display("%0d results compared, %0d of them reporting released buttons",
               checked, release_reports);
      if (failures == 0 && outstanding == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/kdhd_pkg.sv
rtl/core/kdhd_button_cell.sv
rtl/core/keypad_debounce_hold_detect_unit.sv
bench/keypad_debounce_hold_detect_unit_checker.sv
bench/keypad_debounce_hold_detect_unit_tb.sv
